@@ rtl/rsa_crt_cipher_defines.svh @@
// assertion macros of the port checker
`ifndef RSA_CRT_CIPHER_DEFINES_SVH
`define RSA_CRT_CIPHER_DEFINES_SVH

// property checked outside reset
`define RCC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define RCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rcc_pkg.sv @@
// types and constants of the rsa crt cipher
`timescale 1ns / 1ps

package rcc_pkg;

  localparam int VALUE_W    = 16;
  localparam int PRIME_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_EXP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_EXP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_SECOND = 3'd4;

  // action codes
  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  // operations of the shared modular unit
  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_MUL,
    OP_ADD
  } mu_op_t;

  typedef struct packed {
    logic   start;
    mu_op_t op;
  } mu_req_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_ENC_B,
    S_ENC_DONE,
    S_PW_MUL,
    S_PW_R,
    S_PW_SQ,
    S_PW_B,
    S_INV_INIT,
    S_INV,
    S_INV_ACC,
    S_DP,
    S_DQ,
    S_M1_B,
    S_M1_DONE,
    S_M2,
    S_M2_B,
    S_M2_DONE,
    S_M2P,
    S_DIFF,
    S_H,
    S_OUT
  } st_t;

endpackage

@@ rtl/rcc_if.sv @@
// handshake channels of the rsa crt cipher
`timescale 1ns / 1ps

interface rcc_req_if import rcc_pkg::*;;
  logic               valid;
  logic               ready;
  logic               action;
  logic [VALUE_W-1:0] value;
  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

interface rcc_rsp_if import rcc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] result;
  logic               error;
  modport source (output valid, result, error, input ready);
  modport sink (input valid, result, error, output ready);
endinterface

interface rcc_cfg_if import rcc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/rcc_modunit.sv @@
// shared bit-serial modular unit: reduce, multiply and add modulo m
`timescale 1ns / 1ps

module rcc_modunit import rcc_pkg::*; #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  mu_req_t      req,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] res
);

  localparam int CW = $clog2(W + 1);

  logic         busy;
  mu_op_t       op;
  logic [W-1:0] acc;
  logic [W-1:0] aa;
  logic [W-1:0] bb;
  logic [W-1:0] mm;
  logic [CW-1:0] cnt;
  logic [W:0]   red_t;
  logic [W-1:0] red_next;

  // modular add, both operands below the modulus
  function automatic logic [W-1:0] addmod(input logic [W-1:0] x, input logic [W-1:0] y,
                                          input logic [W-1:0] mo);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, mo}) begin
      s = s - {1'b0, mo};
    end
    return s[W-1:0];
  endfunction

  // one restoring remainder step
  always_comb begin
    red_t = {acc, aa[W-1]};
    if (red_t >= {1'b0, mm}) begin
      red_next = W'(red_t - {1'b0, mm});
    end else begin
      red_next = red_t[W-1:0];
    end
  end

  // operation sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        acc  <= '0;
        aa   <= a;
        bb   <= b;
        mm   <= m;
        cnt  <= CW'(W);
      end else if (busy) begin
        unique case (op)
          OP_REDUCE: begin
            acc <= red_next;
            aa  <= aa << 1;
            cnt <= cnt - CW'(1);
            if (cnt == CW'(1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          OP_MUL: begin
            if (bb == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              if (bb[0]) begin
                acc <= addmod(acc, aa, mm);
              end
              aa <= addmod(aa, aa, mm);
              bb <= bb >> 1;
            end
          end
          OP_ADD: begin
            acc  <= addmod(aa, bb, mm);
            busy <= 1'b0;
            done <= 1'b1;
          end
          default: begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

  assign res = acc;

endmodule

@@ rtl/rsa_crt_cipher.sv @@
// top level of the rsa crt cipher
`timescale 1ns / 1ps
// Small-key RSA unit. One request carries an action and a value; one
// response carries the result and an error flag.
// - req channel: action 0 encrypts (value^e mod n), action 1 decrypts with
//   the two primes p and q and the Chinese remainder theorem.
// - rsp channel: result and error; error is set on decrypt when q has no
//   inverse modulo p or a prime is below two, and then the result is 0.
// - cfg channel: register writes (0 modulus, 1 public exponent, 2 private
//   exponent, 3 first prime, 4 second prime); always ready, other indexes
//   are ignored. Write only while no request is in progress.
// Arithmetic: modular reductions, multiplications and additions all go through
// one shared bit-serial modular unit, one operand bit per cycle. Decrypt adds
// a modular inverse search over the candidates below p.
// One request is in flight at a time: req.ready is high only while idle,
// and the next request is taken after the response transfer.
// A stalled response holds its payload until rsp.ready. Reset clears the
// sequencer and loads the registers with 187, 3, 107, 11 and 17.
module rsa_crt_cipher import rcc_pkg::*; #(
  parameter int KEY_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  rcc_cfg_if.sink   cfg,
  rcc_req_if.sink   req,
  rcc_rsp_if.source rsp
);

  localparam int W = (KEY_WIDTH < VALUE_W) ? KEY_WIDTH : VALUE_W;

  st_t st, st_next;
  st_t after, after_next;
  st_t pw_ret;

  logic [W-1:0]       modulus;
  logic [W-1:0]       public_exponent;
  logic [W-1:0]       private_exponent;
  logic [PRIME_W-1:0] prime_first;
  logic [PRIME_W-1:0] prime_second;

  logic               action;
  logic [W-1:0]       value;
  logic [W-1:0]       res;
  logic               err;
  logic [W-1:0]       pw_b, pw_r, pw_e, pw_m;
  logic [PRIME_W-1:0] qm, x, acc, inv, dp, dq, m1, m2;

  mu_req_t      u_req;
  logic [W-1:0] u_a, u_b, u_m, u_res;
  logic         u_done;

  logic               enc_zero, mod_small, prime_bad, inv_hit, inv_end;
  logic [PRIME_W-1:0] m2p, diff;
  logic [PRIME_W:0]   diff_wide;
  logic [VALUE_W-1:0] crt_sum;

  rcc_modunit #(.W(W)) u_mu (
    .clk  (clk),
    .rst  (rst),
    .req  (u_req),
    .a    (u_a),
    .b    (u_b),
    .m    (u_m),
    .done (u_done),
    .res  (u_res)
  );

  // decision terms
  assign enc_zero  = (public_exponent == '0);
  assign mod_small = (modulus <= W'(1));
  assign prime_bad = (prime_first < PRIME_W'(2)) || (prime_second < PRIME_W'(2));
  assign inv_hit   = (acc == PRIME_W'(1));
  assign inv_end   = (x == prime_first - PRIME_W'(1));
  assign m2p       = u_res[PRIME_W-1:0];

  // (m1 - m2) mod p
  always_comb begin
    if (m1 >= m2p) begin
      diff_wide = {1'b0, m1} - {1'b0, m2p};
    end else begin
      diff_wide = {1'b0, m1} + {1'b0, prime_first} - {1'b0, m2p};
    end
    diff = diff_wide[PRIME_W-1:0];
  end

  assign crt_sum = VALUE_W'(u_res[PRIME_W-1:0]) * VALUE_W'(prime_second) + VALUE_W'(m2);

  // next state
  always_comb begin
    st_next    = st;
    after_next = after;
    unique case (st)
      S_IDLE:     if (req.valid) st_next = S_START;
      S_START: begin
        if (action == ACT_ENCRYPT) begin
          if (enc_zero || mod_small) begin
            st_next = S_OUT;
          end else begin
            st_next = S_WAIT; after_next = S_ENC_B;
          end
        end else if (prime_bad) begin
          st_next = S_OUT;
        end else begin
          st_next = S_WAIT; after_next = S_INV_INIT;
        end
      end
      S_WAIT:     if (u_done) st_next = after;
      S_ENC_B:    st_next = S_PW_MUL;
      S_ENC_DONE: st_next = S_OUT;
      S_PW_MUL: begin
        if (pw_e == '0) begin
          st_next = pw_ret;
        end else if (pw_e[0]) begin
          st_next = S_WAIT; after_next = S_PW_R;
        end else begin
          st_next = S_PW_SQ;
        end
      end
      S_PW_R:     st_next = S_PW_SQ;
      S_PW_SQ: begin
        st_next = S_WAIT; after_next = S_PW_B;
      end
      S_PW_B:     st_next = S_PW_MUL;
      S_INV_INIT: st_next = S_INV;
      S_INV: begin
        if (inv_hit) begin
          st_next = S_WAIT; after_next = S_DP;
        end else if (inv_end) begin
          st_next = S_OUT;
        end else begin
          st_next = S_WAIT; after_next = S_INV_ACC;
        end
      end
      S_INV_ACC:  st_next = S_INV;
      S_DP: begin
        st_next = S_WAIT; after_next = S_DQ;
      end
      S_DQ: begin
        if (dp == '0) begin
          st_next = S_M2;
        end else begin
          st_next = S_WAIT; after_next = S_M1_B;
        end
      end
      S_M1_B:     st_next = S_PW_MUL;
      S_M1_DONE:  st_next = S_M2;
      S_M2: begin
        if (dq == '0) begin
          st_next = S_M2P;
        end else begin
          st_next = S_WAIT; after_next = S_M2_B;
        end
      end
      S_M2_B:     st_next = S_PW_MUL;
      S_M2_DONE:  st_next = S_M2P;
      S_M2P: begin
        st_next = S_WAIT; after_next = S_DIFF;
      end
      S_DIFF: begin
        st_next = S_WAIT; after_next = S_H;
      end
      S_H:        st_next = S_OUT;
      S_OUT:      if (rsp.ready) st_next = S_IDLE;
      default:    st_next = S_IDLE;
    endcase
  end

  // requests to the modular unit
  always_comb begin
    u_req = '{start: 1'b0, op: OP_REDUCE};
    u_a   = '0;
    u_b   = '0;
    u_m   = '0;
    unique case (st)
      S_START: begin
        if (action == ACT_ENCRYPT) begin
          u_req.start = !(enc_zero || mod_small);
          u_a = value;
          u_m = modulus;
        end else begin
          u_req.start = !prime_bad;
          u_a = W'(prime_second);
          u_m = W'(prime_first);
        end
      end
      S_PW_MUL: begin
        u_req = '{start: (pw_e != '0) && pw_e[0], op: OP_MUL};
        u_a = pw_r;
        u_b = pw_b;
        u_m = pw_m;
      end
      S_PW_SQ: begin
        u_req = '{start: 1'b1, op: OP_MUL};
        u_a = pw_b;
        u_b = pw_b;
        u_m = pw_m;
      end
      S_INV: begin
        if (inv_hit) begin
          u_req = '{start: 1'b1, op: OP_REDUCE};
          u_a = private_exponent;
          u_m = W'(prime_first) - W'(1);
        end else begin
          u_req = '{start: !inv_end, op: OP_ADD};
          u_a = W'(acc);
          u_b = W'(qm);
          u_m = W'(prime_first);
        end
      end
      S_DP: begin
        u_req.start = 1'b1;
        u_a = private_exponent;
        u_m = W'(prime_second) - W'(1);
      end
      S_DQ: begin
        u_req.start = (dp != '0);
        u_a = value;
        u_m = W'(prime_first);
      end
      S_M2: begin
        u_req.start = (dq != '0);
        u_a = value;
        u_m = W'(prime_second);
      end
      S_M2P: begin
        u_req.start = 1'b1;
        u_a = W'(m2);
        u_m = W'(prime_first);
      end
      S_DIFF: begin
        u_req = '{start: 1'b1, op: OP_MUL};
        u_a = W'(inv);
        u_b = W'(diff);
        u_m = W'(prime_first);
      end
      default: begin
        u_req.start = 1'b0;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      after <= S_IDLE;
    end else begin
      st    <= st_next;
      after <= after_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= W'(187);
      public_exponent  <= W'(3);
      private_exponent <= W'(107);
      prime_first      <= PRIME_W'(11);
      prime_second     <= PRIME_W'(17);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MODULUS:      modulus          <= cfg.data[W-1:0];
        REG_PUBLIC_EXP:   public_exponent  <= cfg.data[W-1:0];
        REG_PRIVATE_EXP:  private_exponent <= cfg.data[W-1:0];
        REG_PRIME_FIRST:  prime_first      <= cfg.data[PRIME_W-1:0];
        REG_PRIME_SECOND: prime_second     <= cfg.data[PRIME_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: begin
        action <= req.action;
        value  <= req.value[W-1:0];
        err    <= 1'b0;
      end
      S_START: begin
        if (action == ACT_ENCRYPT) begin
          res <= enc_zero ? W'(1) : '0;
        end else begin
          res <= '0;
          err <= prime_bad;
        end
      end
      S_ENC_B: begin
        pw_b   <= u_res;
        pw_r   <= W'(1);
        pw_e   <= public_exponent;
        pw_m   <= modulus;
        pw_ret <= S_ENC_DONE;
      end
      S_ENC_DONE: res <= pw_r;
      S_PW_R:     pw_r <= u_res;
      S_PW_B: begin
        pw_b <= u_res;
        pw_e <= pw_e >> 1;
      end
      S_INV_INIT: begin
        qm  <= u_res[PRIME_W-1:0];
        acc <= u_res[PRIME_W-1:0];
        x   <= PRIME_W'(1);
      end
      S_INV: begin
        if (inv_hit) begin
          inv <= x;
        end else if (inv_end) begin
          err <= 1'b1;
        end else begin
          x <= x + PRIME_W'(1);
        end
      end
      S_INV_ACC:  acc <= u_res[PRIME_W-1:0];
      S_DP:       dp <= u_res[PRIME_W-1:0];
      S_DQ: begin
        dq <= u_res[PRIME_W-1:0];
        m1 <= PRIME_W'(1);
      end
      S_M1_B: begin
        pw_b   <= u_res;
        pw_r   <= W'(1);
        pw_e   <= W'(dp);
        pw_m   <= W'(prime_first);
        pw_ret <= S_M1_DONE;
      end
      S_M1_DONE:  m1 <= pw_r[PRIME_W-1:0];
      S_M2:       m2 <= PRIME_W'(1);
      S_M2_B: begin
        pw_b   <= u_res;
        pw_r   <= W'(1);
        pw_e   <= W'(dq);
        pw_m   <= W'(prime_second);
        pw_ret <= S_M2_DONE;
      end
      S_M2_DONE:  m2 <= pw_r[PRIME_W-1:0];
      S_H:        res <= crt_sum[W-1:0];
      default: ;
    endcase
  end

  // channel outputs
  assign cfg.ready  = 1'b1;
  assign req.ready  = (st == S_IDLE);
  assign rsp.valid  = (st == S_OUT);
  assign rsp.result = VALUE_W'(res);
  assign rsp.error  = err;

endmodule

@@ rtl/rcc_checker.sv @@
// port checker of the rsa crt cipher and its binding
`timescale 1ns / 1ps
`include "rsa_crt_cipher_defines.svh"

module rcc_checker import rcc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [VALUE_W-1:0] rsp_result,
  input logic               rsp_error
);

  // one request in flight: no new transfer while a response waits
  `RCC_ASSERT(a_busy_resp, clk, rst, rsp_valid |-> !req_ready, "request taken during response")

  // a request transfer closes the request side
  `RCC_ASSERT(a_busy_after_req, clk, rst, (req_valid && req_ready) |=> !req_ready, "ready after transfer")

  // an error response carries a zero result
  `RCC_ASSERT(a_err_zero, clk, rst, (rsp_valid && rsp_error) |-> (rsp_result == '0), "error with result")

  // a stalled response holds
  `RCC_ASSERT(a_rsp_hold, clk, rst, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result) && $stable(rsp_error)), "response dropped")

  // no response right after reset
  `RCC_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !rsp_valid, "response after reset")

endmodule

bind rsa_crt_cipher rcc_checker u_rcc_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_result (rsp.result),
  .rsp_error  (rsp.error)
);
